@@ hdl/mlk_pkg.sv @@
// Shared types, constants and the letter code table for the Morse letter keyer.
// No dependencies; every other file but mlk_chan_if imports this package.
package mlk_pkg;

   localparam int unsigned UNIT_W    = 16;
   localparam int unsigned COUNT_W   = 18;
   localparam int unsigned ELEM_W    = 3;
   localparam int unsigned PATTERN_W = 4;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned INDEX_W   = 5;

   localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(150);

   localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CODE_W-1:0] CASE_FOLD_MASK = 8'hDF;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_CHAR = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_MARK  = 2'd1,
      PH_SPACE = 2'd2
   } phase_type;

   typedef struct packed {
      logic              mode;
      logic [CODE_W-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic lamp;
      logic busy_res;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [UNIT_W-1:0] unit_ticks;
   } csr_type;

   // Packed letter codes: [7:6] element count minus one, [3:0] elements,
   // first element in bit 0, 1 is long.
   function automatic logic [CODE_W-1:0] letter_code(input logic [INDEX_W-1:0] idx);
      logic [CODE_W-1:0] code;
      unique case (idx)
         5'd0:  code = 8'h42;
         5'd1:  code = 8'hC1;
         5'd2:  code = 8'hC5;
         5'd3:  code = 8'h81;
         5'd4:  code = 8'h00;
         5'd5:  code = 8'hC4;
         5'd6:  code = 8'h83;
         5'd7:  code = 8'hC0;
         5'd8:  code = 8'h40;
         5'd9:  code = 8'hCE;
         5'd10: code = 8'h85;
         5'd11: code = 8'hC2;
         5'd12: code = 8'h43;
         5'd13: code = 8'h41;
         5'd14: code = 8'h87;
         5'd15: code = 8'hC6;
         5'd16: code = 8'hCB;
         5'd17: code = 8'h82;
         5'd18: code = 8'h80;
         5'd19: code = 8'h01;
         5'd20: code = 8'h84;
         5'd21: code = 8'hC8;
         5'd22: code = 8'h86;
         5'd23: code = 8'hC9;
         5'd24: code = 8'hCD;
         5'd25: code = 8'hC3;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

@@ hdl/mlk_chan_if.sv @@
// Valid/ready channel interface used for the request, response and CSR ports.
// The payload type is handed in as a type parameter; types come from mlk_pkg.
interface mlk_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/mlk_core.sv @@
// Keyer state machine: phase, element and tick counters, next state and result.
// Depends on mlk_pkg for types and the letter code table.
module mlk_core
   import mlk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  req_type             item,
   input  logic [UNIT_W-1:0]   unit_ticks,
   output rsp_type             result
);

   phase_type              phase_ff, phase_in;
   logic [ELEM_W-1:0]      elem_left_ff, elem_left_in;
   logic [PATTERN_W-1:0]   pattern_ff, pattern_in;
   logic [COUNT_W-1:0]     tick_cnt_ff, tick_cnt_in;

   logic [COUNT_W-1:0]     unit_len;
   logic [COUNT_W-1:0]     tick_dec;
   logic                   is_upper, is_lower, is_letter;
   logic [CODE_W-1:0]      folded;
   logic [INDEX_W-1:0]     letter_idx;
   logic [CODE_W-1:0]      code;
   logic                   rejected;

   // Mark length: one unit for a short element, three for a long one.
   function automatic logic [COUNT_W-1:0] mark_len(input logic is_long,
                                                   input logic [COUNT_W-1:0] unit);
      return is_long ? ((unit << 1) + unit) : unit;
   endfunction

   assign unit_len = (unit_ticks == '0) ? COUNT_W'(1) : COUNT_W'(unit_ticks);
   assign tick_dec = (tick_cnt_ff != '0) ? tick_cnt_ff - COUNT_W'(1) : tick_cnt_ff;

   assign is_upper   = (item.char_code >= CHAR_UPPER_A) && (item.char_code <= CHAR_UPPER_Z);
   assign is_lower   = (item.char_code >= CHAR_LOWER_A) && (item.char_code <= CHAR_LOWER_Z);
   assign is_letter  = is_upper || is_lower;
   assign folded     = item.char_code & CASE_FOLD_MASK;
   assign letter_idx = INDEX_W'(folded - CHAR_UPPER_A);
   assign code       = letter_code(letter_idx);

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      elem_left_in = elem_left_ff;
      pattern_in   = pattern_ff;
      tick_cnt_in  = tick_cnt_ff;
      rejected     = 1'b0;
      if (item.mode == MODE_TICK) begin
         if (phase_ff != PH_IDLE) begin
            tick_cnt_in = tick_dec;
            if (tick_dec == '0) begin
               priority if (phase_ff == PH_MARK) begin
                  phase_in    = PH_SPACE;
                  tick_cnt_in = unit_len;
               end else if (elem_left_ff != '0) begin
                  elem_left_in = elem_left_ff - ELEM_W'(1);
                  pattern_in   = pattern_ff >> 1;
                  phase_in     = PH_MARK;
                  tick_cnt_in  = mark_len(pattern_ff[1], unit_len);
               end else begin
                  phase_in   = PH_IDLE;
                  pattern_in = '0;
               end
            end
         end
      end else begin
         if (!is_letter || phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            elem_left_in = ELEM_W'(code[7:6]);
            pattern_in   = code[PATTERN_W-1:0];
            phase_in     = PH_MARK;
            tick_cnt_in  = mark_len(code[0], unit_len);
         end
      end
   end

   // Outputs: levels as they stand after this item.
   always_comb begin
      result.lamp     = (phase_in == PH_MARK);
      result.busy_res = (phase_in != PH_IDLE);
      result.rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elem_left_ff <= '0;
         pattern_ff   <= '0;
         tick_cnt_ff  <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         elem_left_ff <= elem_left_in;
         pattern_ff   <= pattern_in;
         tick_cnt_ff  <= tick_cnt_in;
      end
   end

endmodule

@@ hdl/morse_letter_keyer_top.sv @@
// Top level of the Morse letter keyer: CSR register, keyer core, response skid.
// Depends on mlk_pkg, mlk_chan_if and mlk_core.
//
// Usage:
//   req_chan carries one item per handshake: mode 0 is one time tick, mode 1
//   offers a character in char_code. Every item yields exactly one response
//   item on rsp_chan: lamp level and busy flag as they stand after the item,
//   and rejected, set when an offered character is not A to Z (either case)
//   or arrives while a letter is still being keyed.
//   csr_chan writes unit_ticks, the ticks in one Morse unit (0 acts as 1).
//   It is always ready; a new unit applies from the next mark or space loaded.
//
// Throughput and response path:
//   One item per clock cycle while req_chan.ready is high; the response is registered
//   in the response register, or in the skid register while that one is stalled. The
//   per-item work is one pass through the core's next-state logic into the response register.
//
// Reset (synchronous, active high): unit_ticks returns to 150, the keyer is
// idle with the lamp off, and no response is pending.
//
// Stalls: the response register is backed by a one-entry skid register, so a
// new item is still taken while one response waits. req_chan.ready drops only
// when both are full and rises again once the receiver takes a response.
module morse_letter_keyer_top
   import mlk_pkg::*;
(
   input logic        clock,
   input logic        reset,
   mlk_chan_if.sink   req_chan,
   mlk_chan_if.source rsp_chan,
   mlk_chan_if.sink   csr_chan
);

   logic [UNIT_W-1:0] unit_ff;
   req_type           req_item;
   csr_type           csr_item;
   rsp_type           core_result;
   logic              accept;
   logic              take;

   rsp_type           out_ff;
   logic              out_valid_ff;
   rsp_type           skid_ff;
   logic              skid_valid_ff;

   assign req_item = req_chan.payload;
   assign csr_item = csr_chan.payload;

   // Hold off new items only when both response and skid are occupied.
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = out_valid_ff && rsp_chan.ready;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
      end else if (csr_chan.valid) begin
         unit_ff <= csr_item.unit_ticks;
      end
   end

   mlk_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .item       (req_item),
      .unit_ticks (unit_ff),
      .result     (core_result)
   );

   // Response control: refill from skid first, then from the core.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !take) begin
         if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end
   end

   // Response payload: no reset needed.
   always_ff @(posedge clock) begin
      if (out_valid_ff && !take) begin
         if (accept) begin
            skid_ff <= core_result;
         end
      end else begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= core_result;
         end
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

@@ hdl/mlk_checker.sv @@
// Port-level checks for the Morse letter keyer, bound onto the top level.
// Depends on mlk_pkg for the response type.
module mlk_checker
   import mlk_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // Response register comes out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Input back-pressure only when a response is pending.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A lit lamp means a letter is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.lamp |-> rsp_payload.busy_res)
      else $error("lamp on while not busy");

   // Stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Stalled response payload holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

endmodule

bind morse_letter_keyer_top mlk_checker u_mlk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

@@ bench/tb_top.sv @@
// Self-checking bench for morse_letter_keyer_top: a directed table, then random ticks and letters.
// Depends on mlk_pkg, mlk_chan_if and the keyer RTL; every response is checked against the predictor or a typed row.
`timescale 1ns / 1ps

module tb_top;
   import mlk_pkg::*;

   // Run ends here even if the keyer hangs.
   localparam int CYCLE_LIMIT = 100_000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 244;
   localparam int LONG_STALL = 60;

   // Letter codes A..Z, A in the low byte: [7:6] element count minus one, [3:0] elements
   // with the first in bit 0, a one meaning a long element.
   localparam logic [26*8-1:0] MORSE_CODES = {
      8'hC3, 8'hCD, 8'hC9, 8'h86, 8'hC8, 8'h84, 8'h01, 8'h80, 8'h82, 8'hCB,
      8'hC6, 8'h87, 8'h41, 8'h43, 8'hC2, 8'h85, 8'hCE, 8'h40, 8'hC0, 8'h83,
      8'hC4, 8'h00, 8'h81, 8'hC5, 8'hC1, 8'h42};

   localparam rsp_type RSP_DARK          = '{lamp: 1'b0, busy_res: 1'b0, rejected: 1'b0};
   localparam rsp_type RSP_DARK_REFUSED  = '{lamp: 1'b0, busy_res: 1'b0, rejected: 1'b1};
   localparam rsp_type RSP_LIT           = '{lamp: 1'b1, busy_res: 1'b1, rejected: 1'b0};
   localparam rsp_type RSP_LIT_REFUSED   = '{lamp: 1'b1, busy_res: 1'b1, rejected: 1'b1};
   localparam rsp_type RSP_GAP           = '{lamp: 1'b0, busy_res: 1'b1, rejected: 1'b0};
   localparam rsp_type RSP_GAP_REFUSED   = '{lamp: 1'b0, busy_res: 1'b1, rejected: 1'b1};

   typedef enum logic [1:0] {
      ROW_ITEM = 2'd0,
      ROW_UNIT = 2'd1
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              mode;
      logic [CODE_W-1:0] char_code;
      logic [UNIT_W-1:0] unit;
      logic              typed;
      rsp_type           rsp;
   } plan_row_type;

   // Directed opening: idle ticks, refused codes at the letter boundaries, a refusal while
   // busy in mark and in space, a zero unit, and a unit change in the middle of a letter.
   // Rows with typed = 0 take their expectation from the predictor.
   localparam plan_row_type DIRECTED_PLAN [25] = '{
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b1, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h41, 16'd0, 1'b1, RSP_DARK},
      '{ROW_ITEM, MODE_CHAR, 8'h00, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_ITEM, MODE_CHAR, 8'hFF, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_ITEM, MODE_CHAR, 8'h40, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_ITEM, MODE_CHAR, 8'h5B, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_ITEM, MODE_CHAR, 8'h60, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_ITEM, MODE_CHAR, 8'h7B, 16'd0, 1'b1, RSP_DARK_REFUSED},
      '{ROW_UNIT, MODE_TICK, 8'h00, 16'd1, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_CHAR, 8'h45, 16'd0, 1'b1, RSP_LIT},
      '{ROW_ITEM, MODE_CHAR, 8'h5A, 16'd0, 1'b1, RSP_LIT_REFUSED},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b1, RSP_GAP},
      '{ROW_ITEM, MODE_CHAR, 8'h61, 16'd0, 1'b1, RSP_GAP_REFUSED},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b1, RSP_DARK},
      '{ROW_UNIT, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_CHAR, 8'h61, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK},
      '{ROW_UNIT, MODE_TICK, 8'h00, 16'd3, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'hA5, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h5A, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_CHAR, 8'h7A, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK},
      '{ROW_ITEM, MODE_TICK, 8'h00, 16'd0, 1'b0, RSP_DARK}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlk_chan_if #(.payload_type(req_type)) req_chan ();
   mlk_chan_if #(.payload_type(rsp_type)) rsp_chan ();
   mlk_chan_if #(.payload_type(csr_type)) csr_chan ();

   morse_letter_keyer_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted keyer state and register copy.
   phase_type            kp_phase;
   logic [ELEM_W-1:0]    kp_elems;
   logic [PATTERN_W-1:0] kp_pattern;
   logic [COUNT_W-1:0]   kp_ticks;
   logic [UNIT_W-1:0]    kp_unit;

   rsp_type pending_lamp_states [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      rsp_hold_req = 0;
   int      stall_left = 0;
   rsp_type want_rsp;
   rsp_type got_rsp;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] unit_span();
      return (kp_unit == '0) ? COUNT_W'(1) : COUNT_W'(kp_unit);
   endfunction

   // Load the current element's mark: three units when long, one when short.
   function automatic void load_mark();
      kp_phase = PH_MARK;
      kp_ticks = kp_pattern[0] ? COUNT_W'(unit_span() * 3) : unit_span();
   endfunction

   // Advance the predicted keyer by one item and return the response it should give.
   function automatic rsp_type next_lamp_state(input req_type item);
      rsp_type           result;
      int                slot;
      logic [CODE_W-1:0] code;
      result = RSP_DARK;
      slot = -1;
      if (item.mode == MODE_TICK) begin
         if (kp_phase != PH_IDLE) begin
            if (kp_ticks != '0) kp_ticks = kp_ticks - 1'b1;
            if (kp_ticks == '0) begin
               if (kp_phase == PH_MARK) begin
                  kp_phase = PH_SPACE;
                  kp_ticks = unit_span();
               end else if (kp_elems != '0) begin
                  kp_elems = kp_elems - 1'b1;
                  kp_pattern = kp_pattern >> 1;
                  load_mark();
               end else begin
                  kp_phase = PH_IDLE;
                  kp_pattern = '0;
               end
            end
         end
      end else begin
         if (item.char_code >= CHAR_UPPER_A && item.char_code <= CHAR_UPPER_Z)
            slot = int'(item.char_code - CHAR_UPPER_A);
         else if (item.char_code >= CHAR_LOWER_A && item.char_code <= CHAR_LOWER_Z)
            slot = int'(item.char_code - CHAR_LOWER_A);
         if (slot < 0 || kp_phase != PH_IDLE) begin
            result.rejected = 1'b1;
         end else begin
            code = MORSE_CODES[slot*8 +: 8];
            kp_elems = ELEM_W'(code[7:6]);
            kp_pattern = code[3:0];
            load_mark();
         end
      end
      result.lamp = (kp_phase == PH_MARK);
      result.busy_res = (kp_phase != PH_IDLE);
      return result;
   endfunction

   // Offer one item, idling first at the current rate, and record its expected response
   // once it is accepted. A typed response replaces the predicted one.
   task automatic offer_item(input req_type item, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      predicted = next_lamp_state(item);
      pending_lamp_states.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic offer_tick();
      req_type item;
      item.mode = MODE_TICK;
      item.char_code = CODE_W'($urandom);
      offer_item(item, 1'b0, RSP_DARK);
   endtask

   // Write unit_ticks once every outstanding response has come back.
   task automatic set_unit_ticks(input logic [UNIT_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (pending_lamp_states.size() != 0) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= csr_type'(value);
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      kp_unit = value;
   endtask

   // Random item: mostly ticks; letters are likely while idle so letters keep getting keyed,
   // rare while busy so refusals in mark and space still show up; some raw codes as noise.
   function automatic req_type random_item();
      req_type item;
      int      roll;
      int      letter_pct;
      roll = $urandom_range(99);
      letter_pct = (kp_phase == PH_IDLE) ? 55 : 6;
      item.mode = MODE_TICK;
      item.char_code = CODE_W'($urandom);
      if (roll < letter_pct) begin
         item.mode = MODE_CHAR;
         item.char_code = ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A)
                          + CODE_W'($urandom_range(25));
      end else if (roll >= 95) begin
         item.mode = MODE_CHAR;
      end
      return item;
   endfunction

   // Response side: check each accepted item against the oldest expectation, then pick
   // ready for the next cycle. A long hold requested by the sender is counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_rsp = rsp_chan.payload;
            if (pending_lamp_states.size() == 0) begin
               $error("unexpected response item: lamp %0b busy_res %0b rejected %0b",
                      got_rsp.lamp, got_rsp.busy_res, got_rsp.rejected);
               mismatch_count++;
            end else begin
               want_rsp = pending_lamp_states.pop_front();
               if (got_rsp.lamp !== want_rsp.lamp) begin
                  $error("lamp: expected %0b, got %0b", want_rsp.lamp, got_rsp.lamp);
                  mismatch_count++;
               end
               if (got_rsp.busy_res !== want_rsp.busy_res) begin
                  $error("busy_res: expected %0b, got %0b", want_rsp.busy_res, got_rsp.busy_res);
                  mismatch_count++;
               end
               if (got_rsp.rejected !== want_rsp.rejected) begin
                  $error("rejected: expected %0b, got %0b", want_rsp.rejected, got_rsp.rejected);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_req > 0) begin
            stall_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req_type      item;
      plan_row_type row;
      // Drive every input to a known level from time zero.
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.payload <= '0;
      kp_phase = PH_IDLE;
      kp_elems = '0;
      kp_pattern = '0;
      kp_ticks = '0;
      kp_unit = UNIT_RESET;

      // Hold reset at the start, then release it once.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table, both sides at full rate.
      for (int r = 0; r < 25; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_UNIT) begin
            set_unit_ticks(row.unit);
         end else begin
            item.mode = row.mode;
            item.char_code = row.char_code;
            offer_item(item, row.typed, row.rsp);
         end
      end

      // Finish the letter in flight before the random phases.
      while (kp_phase != PH_IDLE) offer_tick();

      // Random phases: rotate through the idling patterns, new unit each phase.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         unique case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 59;
            end
            default: begin
               send_idle_pct = 38;
               recv_stall_pct = 38;
            end
         endcase
         if (p == 3)
            set_unit_ticks('0);
         else if (p == 6)
            set_unit_ticks(UNIT_W'($urandom_range(5, 12)));
         else
            set_unit_ticks(UNIT_W'($urandom_range(1, 4)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Stall the receiver for a long stretch while items keep coming, so the
            // response skid fills and the request side backs up.
            if (n == 100 && (p == 0 || p == 4)) rsp_hold_req = LONG_STALL;
            // Drop valid and drain every outstanding response before going on.
            if (n == 120 && (p == 1 || p == 5)) begin
               req_chan.valid <= 1'b0;
               while (pending_lamp_states.size() != 0) @(posedge clock);
            end
            offer_item(random_item(), 1'b0, RSP_DARK);
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_lamp_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
